/* design/assert_macros.svh */
// Assertion macros shared by the zero-suppression design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on clk_i, disabled while rst_ni is low
`define WZS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define WZS_NEVER(lbl, cond, msg) \
  `WZS_ASSERT(lbl, !(cond), msg)

`endif

/* design/wzs_pkg.sv */
// Shared constants and controller/datapath interface types for zero suppression.
package wzs_pkg;

  localparam int unsigned MAX_WORDS = 1024;
  localparam int unsigned CHANNELS  = 8;
  localparam int unsigned HDR_WORDS = 4;
  localparam int unsigned CH_SHIFT  = 12;

  localparam int unsigned W_BITS   = $clog2(MAX_WORDS);
  localparam int unsigned C_BITS   = $clog2(CHANNELS);
  localparam int unsigned H_BITS   = $clog2(HDR_WORDS);
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ADDR_W   = $clog2(CHANNELS * MAX_WORDS);
  localparam int unsigned CNT_W    = $clog2(HDR_WORDS + CHANNELS + CHANNELS * MAX_WORDS + 1);
  localparam int unsigned KCNT_W   = $clog2(CHANNELS + 1);
  localparam int unsigned SIZE_BITS = 28;

  // configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WORDS     = 2'd1;
  localparam logic [1:0] REG_MARK      = 2'd2;

  // input kinds carried on tuser
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_WORDS);

  // commands from controller to datapath
  typedef struct packed {
    logic push;  // push transaction accepted
    logic pull;  // pull transaction accepted, memory read issued
    logic emit;  // load the output register from the pending result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage

/* design/wzs_ctrl.sv */
// Controller: input handshake and sequencing of pushes and pulls.
`include "assert_macros.svh"

module wzs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          func_i,
  output logic          s_ready_o,
  input  logic          m_ready_i,
  input  wzs_pkg::stat_t stat_i,
  output wzs_pkg::cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_q, state_d;
  logic accept;

  // accept when idle and the output register is free or draining this cycle
  assign s_ready_o = (state_q == ST_IDLE) && (!stat_i.out_full || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    cmd_o.push = accept && (func_i == wzs_pkg::FUNC_PUSH);
    cmd_o.pull = accept && (func_i == wzs_pkg::FUNC_PULL);
    cmd_o.emit = (state_q == ST_RESP);
  end

  // a pull waits in ST_RESP for the registered memory read
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.pull) state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `WZS_ASSERT(a_pull_then_emit, cmd_o.pull |=> cmd_o.emit, "pull not followed by emit")
  `WZS_NEVER(a_no_accept_in_resp, (state_q == ST_RESP) && s_ready_o, "ready while responding")

endmodule

/* design/wzs_dp.sv */
// Datapath: event load, channel range tracking, sample memory and output walk.
`include "assert_macros.svh"

module wzs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wzs_pkg::cmd_t                 cmd_i,
  output wzs_pkg::stat_t                stat_o,
  input  logic [wzs_pkg::WORD_W-1:0]    raw_word_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [wzs_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [wzs_pkg::WORD_W-1:0]    out_word_o,
  output logic                          out_valid_o,
  output logic                          out_last_o
);

  localparam int unsigned W_BITS   = wzs_pkg::W_BITS;
  localparam int unsigned C_BITS   = wzs_pkg::C_BITS;
  localparam int unsigned H_BITS   = wzs_pkg::H_BITS;
  localparam int unsigned LEN_W    = wzs_pkg::LEN_W;
  localparam int unsigned WORD_W   = wzs_pkg::WORD_W;
  localparam int unsigned SW       = wzs_pkg::SAMPLE_W;
  localparam int unsigned ADDR_W   = wzs_pkg::ADDR_W;
  localparam int unsigned CNT_W    = wzs_pkg::CNT_W;
  localparam int unsigned KCNT_W   = wzs_pkg::KCNT_W;
  localparam int unsigned CHANNELS = wzs_pkg::CHANNELS;
  localparam int unsigned MEM_DEPTH = wzs_pkg::CHANNELS * wzs_pkg::MAX_WORDS;

  localparam logic [1:0] PH_HDR = 2'd0;  // event header words
  localparam logic [1:0] PH_CHH = 2'd1;  // channel header word
  localparam logic [1:0] PH_CHD = 2'd2;  // channel data words

  localparam logic [C_BITS-1:0] LAST_CH  = C_BITS'(CHANNELS - 1);
  localparam logic [H_BITS-1:0] LAST_HDR = H_BITS'(wzs_pkg::HDR_WORDS - 1);
  localparam logic [SW-1:0]     MIN_INIT = '1;

  // configuration registers
  logic [wzs_pkg::THR_W-1:0] thr_q;
  logic [LEN_W-1:0]          wpc_q;
  logic [WORD_W-1:0]         mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      wpc_q  <= wzs_pkg::LEN_RESET;
      mark_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wzs_pkg::REG_THRESHOLD: thr_q  <= cfg_data_i[wzs_pkg::THR_W-1:0];
        wzs_pkg::REG_WORDS:     wpc_q  <= cfg_data_i[LEN_W-1:0];
        wzs_pkg::REG_MARK:      mark_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped channel length
  logic [LEN_W-1:0] eff_len;
  always_comb begin
    if (wpc_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (wpc_q > wzs_pkg::LEN_RESET) begin
      eff_len = wzs_pkg::LEN_RESET;
    end else begin
      eff_len = wpc_q;
    end
  end

  // event state
  logic [WORD_W-1:0] hdr_q [wzs_pkg::HDR_WORDS];
  logic [LEN_W-1:0]  ev_len_q,  ev_len_d;
  logic              ld_hdr_q,  ld_hdr_d;
  logic [H_BITS-1:0] ld_h_q,    ld_h_d;
  logic [C_BITS-1:0] ld_c_q,    ld_c_d;
  logic [W_BITS-1:0] ld_w_q,    ld_w_d;
  logic [SW-1:0]     min_q,     min_d;
  logic [SW-1:0]     max_q,     max_d;
  logic [CHANNELS-1:0] keep_q,  keep_d;
  logic              drain_q,   drain_d;
  logic [1:0]        em_ph_q,   em_ph_d;
  logic [H_BITS-1:0] em_h_q,    em_h_d;
  logic [C_BITS-1:0] em_c_q,    em_c_d;
  logic [W_BITS-1:0] em_w_q,    em_w_d;
  logic [CNT_W-1:0]  em_cnt_q,  em_cnt_d;

  // pending result and output register
  logic [WORD_W-1:0] pend_word_q, pend_word_d;
  logic              pend_mem_q,  pend_mem_d;
  logic              pend_last_q, pend_last_d;
  logic              pend_val_q,  pend_val_d;
  logic [WORD_W-1:0] out_word_q;
  logic              out_val_q, out_last_q;
  logic              out_full_q, out_full_d;

  // sample memory
  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign wr_addr = ADDR_W'(ld_c_q) * ADDR_W'(wzs_pkg::MAX_WORDS) + ADDR_W'(ld_w_q);
  assign rd_addr = ADDR_W'(em_c_q) * ADDR_W'(wzs_pkg::MAX_WORDS) + ADDR_W'(em_w_q);
  assign mem_we  = cmd_i.push && !drain_q && !ld_hdr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= raw_word_i;
    end
    if (cmd_i.pull) begin
      rd_q <= mem[rd_addr];
    end
  end

  // running extremes including the incoming word
  logic [SW-1:0]  s_hi, s_lo, w_min, w_max, n_min, n_max;
  logic [SW:0]    range;
  logic           keep_now, ld_wlast;
  assign s_hi    = raw_word_i[2*SW-1:SW];
  assign s_lo    = raw_word_i[SW-1:0];
  assign w_min   = (s_hi < s_lo) ? s_hi : s_lo;
  assign w_max   = (s_hi < s_lo) ? s_lo : s_hi;
  assign n_min   = (w_min < min_q) ? w_min : min_q;
  assign n_max   = (w_max > max_q) ? w_max : max_q;
  assign range   = {1'b0, n_max} - {1'b0, n_min};
  assign keep_now = range >= thr_q;
  assign ld_wlast = (LEN_W'(ld_w_q) + LEN_W'(1)) == ev_len_q;

  // output event size
  logic [KCNT_W-1:0] kcnt;
  logic [CNT_W-1:0]  out_size;
  always_comb begin
    kcnt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      kcnt = kcnt + KCNT_W'(keep_q[i]);
    end
  end
  assign out_size = CNT_W'(wzs_pkg::HDR_WORDS + CHANNELS)
                  + CNT_W'(kcnt) * CNT_W'(ev_len_q);

  logic em_last, em_wlast;
  assign em_last  = (em_cnt_q + CNT_W'(1)) >= out_size;
  assign em_wlast = (LEN_W'(em_w_q) + LEN_W'(1)) == ev_len_q;

  // next-state logic for load and emit walks
  always_comb begin
    ev_len_d = ev_len_q;
    ld_hdr_d = ld_hdr_q;
    ld_h_d   = ld_h_q;
    ld_c_d   = ld_c_q;
    ld_w_d   = ld_w_q;
    min_d    = min_q;
    max_d    = max_q;
    keep_d   = keep_q;
    drain_d  = drain_q;
    em_ph_d  = em_ph_q;
    em_h_d   = em_h_q;
    em_c_d   = em_c_q;
    em_w_d   = em_w_q;
    em_cnt_d = em_cnt_q;
    pend_word_d = pend_word_q;
    pend_mem_d  = pend_mem_q;
    pend_last_d = pend_last_q;
    pend_val_d  = pend_val_q;

    if (cmd_i.push && !drain_q) begin
      if (ld_hdr_q) begin
        if (ld_h_q == '0) ev_len_d = eff_len;
        if (ld_h_q == LAST_HDR) begin
          ld_hdr_d = 1'b0;
          ld_c_d   = '0;
          ld_w_d   = '0;
        end else begin
          ld_h_d = ld_h_q + H_BITS'(1);
        end
      end else if (ld_wlast) begin
        // channel complete: decide keep and restart extremes
        if (keep_now) keep_d[ld_c_q] = 1'b1;
        min_d  = MIN_INIT;
        max_d  = '0;
        ld_w_d = '0;
        if (ld_c_q == LAST_CH) begin
          drain_d = 1'b1;
        end else begin
          ld_c_d = ld_c_q + C_BITS'(1);
        end
      end else begin
        min_d  = n_min;
        max_d  = n_max;
        ld_w_d = ld_w_q + W_BITS'(1);
      end
    end

    if (cmd_i.pull) begin
      if (!drain_q) begin
        pend_word_d = '0;
        pend_mem_d  = 1'b0;
        pend_last_d = 1'b0;
        pend_val_d  = 1'b0;
      end else begin
        pend_val_d  = 1'b1;
        pend_last_d = em_last;
        pend_mem_d  = (em_ph_q == PH_CHD);
        pend_word_d = '0;
        unique case (em_ph_q)
          PH_HDR: begin
            if (em_h_q == H_BITS'(0)) begin
              pend_word_d = {hdr_q[0][WORD_W-1:wzs_pkg::SIZE_BITS],
                             wzs_pkg::SIZE_BITS'(out_size)};
            end else if (em_h_q == H_BITS'(1)) begin
              pend_word_d = hdr_q[1] | mark_q;
            end else begin
              pend_word_d = hdr_q[em_h_q];
            end
            if (em_h_q == LAST_HDR) begin
              em_ph_d = PH_CHH;
              em_c_d  = '0;
            end else begin
              em_h_d = em_h_q + H_BITS'(1);
            end
          end
          PH_CHH: begin
            pend_word_d = (WORD_W'(em_c_q) << wzs_pkg::CH_SHIFT)
                        | (keep_q[em_c_q] ? WORD_W'(ev_len_q) : '0);
            if (keep_q[em_c_q]) begin
              em_ph_d = PH_CHD;
              em_w_d  = '0;
            end else begin
              em_c_d = em_c_q + C_BITS'(1);
            end
          end
          PH_CHD: begin
            if (em_wlast) begin
              em_ph_d = PH_CHH;
              em_c_d  = em_c_q + C_BITS'(1);
            end else begin
              em_w_d = em_w_q + W_BITS'(1);
            end
          end
          default: em_ph_d = PH_HDR;
        endcase
        em_cnt_d = em_cnt_q + CNT_W'(1);
        // event fully drained: start a new one
        if (em_last) begin
          ld_hdr_d = 1'b1;
          ld_h_d   = '0;
          ld_c_d   = '0;
          ld_w_d   = '0;
          min_d    = MIN_INIT;
          max_d    = '0;
          keep_d   = '0;
          drain_d  = 1'b0;
          em_ph_d  = PH_HDR;
          em_h_d   = '0;
          em_c_d   = '0;
          em_w_d   = '0;
          em_cnt_d = '0;
          ev_len_d = eff_len;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_len_q <= wzs_pkg::LEN_RESET;
      ld_hdr_q <= 1'b1;
      ld_h_q   <= '0;
      ld_c_q   <= '0;
      ld_w_q   <= '0;
      min_q    <= MIN_INIT;
      max_q    <= '0;
      keep_q   <= '0;
      drain_q  <= 1'b0;
      em_ph_q  <= PH_HDR;
      em_h_q   <= '0;
      em_c_q   <= '0;
      em_w_q   <= '0;
      em_cnt_q <= '0;
    end else begin
      ev_len_q <= ev_len_d;
      ld_hdr_q <= ld_hdr_d;
      ld_h_q   <= ld_h_d;
      ld_c_q   <= ld_c_d;
      ld_w_q   <= ld_w_d;
      min_q    <= min_d;
      max_q    <= max_d;
      keep_q   <= keep_d;
      drain_q  <= drain_d;
      em_ph_q  <= em_ph_d;
      em_h_q   <= em_h_d;
      em_c_q   <= em_c_d;
      em_w_q   <= em_w_d;
      em_cnt_q <= em_cnt_d;
    end
  end

  // header words and pending result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !drain_q && ld_hdr_q) begin
      hdr_q[ld_h_q] <= raw_word_i;
    end
    pend_word_q <= pend_word_d;
    pend_mem_q  <= pend_mem_d;
    pend_last_q <= pend_last_d;
    pend_val_q  <= pend_val_d;
  end

  // output register
  always_comb begin
    out_full_d = out_full_q;
    if (out_full_q && m_ready_i) out_full_d = 1'b0;
    if (cmd_i.emit) out_full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else begin
      out_full_q <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q <= pend_mem_q ? rd_q : pend_word_q;
      out_val_q  <= pend_val_q;
      out_last_q <= pend_last_q;
    end
  end

  assign stat_o.out_full = out_full_q;
  assign m_valid_o       = out_full_q;
  assign out_word_o      = out_word_q;
  assign out_valid_o     = out_val_q;
  assign out_last_o      = out_last_q;

  `WZS_NEVER(a_emit_into_full, cmd_i.emit && out_full_q && !m_ready_i, "output overwritten")
  `WZS_NEVER(a_idle_emit_count, !drain_q && (em_cnt_q != '0), "emit count while loading")
  `WZS_ASSERT(a_drain_keeps_load, drain_q && !ld_hdr_q |-> ld_c_q == LAST_CH,
              "load walk moved while draining")

endmodule

/* design/waveform_zero_suppression.sv */
// Top level: peak-to-peak zero suppression of one digitizer event.
// Push transaction: one per cycle unless stalled, into the header registers or sample memory
//   (ignored while the event drains). Pull: the result and the sample memory read are registered
//   at the accepting edge and loaded into the output register in ST_RESP, which blocks new input.
// Input stalls while a result waits in the output register and m_axis_tready is low.
// Reset: asynchronous, active low; clears control state, no memory clearing pass.
module waveform_zero_suppression (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] raw_word
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] out_word
  output logic        m_axis_tuser,   // [0] out_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  wzs_pkg::cmd_t  cmd;
  wzs_pkg::stat_t stat;

  wzs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .func_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  wzs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .raw_word_i  (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .out_word_o  (m_axis_tdata),
    .out_valid_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
